/* design/dsfa_pkg.sv */
// dust sensor frame averager package: frame constants, scaling constants, types
// no dependencies; imported by the interfaces and the top level
package dsfa_pkg;

    typedef logic [7:0] byte_t;

    // frame bytes
    localparam byte_t START_BYTE = 8'hAA;
    localparam byte_t END_BYTE   = 8'hFF;

    // reading scale: reading = (total * 45600) >> 16, saturated at 255
    localparam int          TOTAL_W     = 20;
    localparam int          MUL_W       = 16;
    localparam int          SCALE_SHIFT = 16;
    localparam logic [15:0] SCALE_MUL   = 16'd45600;

    // frame count register
    localparam int         CFG_W      = 5;
    localparam logic [4:0] CFG_RESET  = 5'd2;
    localparam logic [4:0] MAX_FRAMES = 5'd16;

    // history sum width (wraps like the 12-bit running sum)
    localparam int SUM_W = 12;

    // parser position in the frame
    typedef enum logic [2:0] {
        POS_HUNT = 3'd0,
        POS_D1   = 3'd1,
        POS_D2   = 3'd2,
        POS_D3   = 3'd3,
        POS_D4   = 3'd4,
        POS_CK   = 3'd5,
        POS_END  = 3'd6
    } frame_pos_t;

endpackage

/* design/dsfa_rx_if.sv */
// received byte channel: valid, ready and one serial byte
// depends on dsfa_pkg
interface dsfa_rx_if
    import dsfa_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* design/dsfa_res_if.sv */
// result channel: valid, ready, history average and newest reading
// depends on dsfa_pkg
interface dsfa_res_if
    import dsfa_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t avg_value;
    byte_t new_reading;

    modport source (output valid, output avg_value, output new_reading, input ready);
    modport sink   (input valid, input avg_value, input new_reading, output ready);
endinterface

/* design/dsfa_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module dsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

/* design/dust_sensor_frame_averager.sv */
// dust sensor frame averager top level: frame parser, reading scaler, history ram
// depends on dsfa_pkg, dsfa_rx_if, dsfa_res_if, dsfa_ram
//
//  channel  | dir | payload                    | handshake
//  ---------+-----+----------------------------+-------------------------------
//  rx       | in  | rx_byte[7:0]               | valid & ready
//  res      | out | avg_value[7:0], new_reading[7:0] | valid & ready
//  cfg      | in  | cfg_wdata[4:0] frames per reading | cfg_we, no wait
//
// one byte is taken every cycle while rx.ready is high; the end byte completing a
// reading passes s1 (multiplier), s2 (ram read), s3 (divide), then the output register.
// rx.ready drops only when the end byte is due while an untaken result still
// sits in the output register. readings are at least seven bytes apart, so the
// history read-modify-write never overlaps itself. reset clears the history
// through per-entry valid bits at once; no clearing pass is needed.
module dust_sensor_frame_averager
    import dsfa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    dsfa_rx_if.sink           rx,
    dsfa_res_if.source        res,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_SHIFT:0] RECIP =
        (RECIP_SHIFT+1)'(((64'd1 << RECIP_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    // configuration and parser state
    logic [CFG_W-1:0]   frames_cfg_reg;
    frame_pos_t         pos_reg, pos_next;
    byte_t              d1_reg, d2_reg, ck_reg;
    logic [9:0]         dsum_reg;
    logic [CFG_W-1:0]   taken_reg;
    logic [TOTAL_W-1:0] total_reg;

    // reading pipeline
    logic               s1_valid_reg;
    logic [TOTAL_W-1:0] s1_total_reg;
    logic               s2_valid_reg;
    byte_t              s2_reading_reg;
    logic               s3_valid_reg;
    logic [SUM_W-1:0]   s3_sum_reg;
    byte_t              s3_reading_reg;

    // history bookkeeping
    logic [IDX_W-1:0]         hidx_reg;
    logic [SUM_W-1:0]         hsum_reg;
    logic [HISTORY_DEPTH-1:0] hvalid_reg;
    byte_t                    ram_rdata;
    byte_t                    old_entry;
    logic [SUM_W-1:0]         hsum_next;

    // output register
    logic  out_valid_reg;
    byte_t out_avg_reg, out_reading_reg;

    logic               accept;
    logic               frame_ok;
    logic [TOTAL_W-1:0] frame_value;
    logic [TOTAL_W-1:0] total_sum;
    logic [CFG_W-1:0]   taken_inc;
    logic [CFG_W-1:0]   frame_limit;
    logic               reading_done;
    logic [TOTAL_W+MUL_W-1:0] scaled;
    byte_t              reading_sat;
    logic [SUM_W+RECIP_SHIFT:0] avg_product;

    assign rx.ready = !(out_valid_reg && (pos_reg == POS_END));
    assign accept   = rx.valid && rx.ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            frames_cfg_reg <= cfg_wdata;
        end
    end

    // frame parser next state
    always_comb
    begin
        pos_next = pos_reg;
        frame_ok = 1'b0;
        unique case (pos_reg)
            POS_D1:  pos_next = POS_D2;
            POS_D2:  pos_next = POS_D3;
            POS_D3:  pos_next = POS_D4;
            POS_D4:  pos_next = POS_CK;
            POS_CK:  pos_next = POS_END;
            POS_END:
            begin
                frame_ok = (rx.rx_byte == END_BYTE) && (dsum_reg == {2'b00, ck_reg});
                if (frame_ok)
                begin
                    pos_next = POS_HUNT;
                end
                else
                begin
                    pos_next = (rx.rx_byte == START_BYTE) ? POS_D1 : POS_HUNT;
                end
            end
            default: pos_next = (rx.rx_byte == START_BYTE) ? POS_D1 : POS_HUNT;
        endcase
    end

    // parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // frame data capture, checksum accumulated on the fly
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (pos_reg) inside
                POS_D1:
                begin
                    d1_reg   <= rx.rx_byte;
                    dsum_reg <= {2'b00, rx.rx_byte};
                end
                POS_D2:
                begin
                    d2_reg   <= rx.rx_byte;
                    dsum_reg <= dsum_reg + {2'b00, rx.rx_byte};
                end
                POS_D3, POS_D4:
                begin
                    dsum_reg <= dsum_reg + {2'b00, rx.rx_byte};
                end
                POS_CK:
                begin
                    ck_reg <= rx.rx_byte;
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame count limit and running total
    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            frame_limit = CFG_W'(1);
        end
        else if (frames_cfg_reg > MAX_FRAMES)
        begin
            frame_limit = MAX_FRAMES;
        end
        else
        begin
            frame_limit = frames_cfg_reg;
        end
        frame_value  = {{(TOTAL_W-16){1'b0}}, d1_reg, d2_reg};
        total_sum    = total_reg + frame_value;
        taken_inc    = taken_reg + CFG_W'(1);
        reading_done = (taken_inc >= frame_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg    <= '0;
            total_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && frame_ok && reading_done;
            if (accept && frame_ok)
            begin
                if (reading_done)
                begin
                    taken_reg <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    taken_reg <= taken_inc;
                    total_reg <= total_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_total_reg <= total_sum;
    end

    // stage 1: scale the total and saturate; history entry read issued
    assign scaled = s1_total_reg * SCALE_MUL;
    assign reading_sat = (scaled[TOTAL_W+MUL_W-1:SCALE_SHIFT+8] != '0)
                         ? 8'hFF : scaled[SCALE_SHIFT+7:SCALE_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reading_reg <= reading_sat;
    end

    // history memory
    dsfa_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (hidx_reg),
        .wdata (s2_reading_reg),
        .raddr (hidx_reg),
        .rdata (ram_rdata)
    );

    // stage 2: replace the oldest entry in the running sum
    assign old_entry = hvalid_reg[hidx_reg] ? ram_rdata : 8'h00;
    assign hsum_next = hsum_reg - {{(SUM_W-8){1'b0}}, old_entry}
                     + {{(SUM_W-8){1'b0}}, s2_reading_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidx_reg     <= '0;
            hsum_reg     <= '0;
            hvalid_reg   <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                hsum_reg             <= hsum_next;
                hvalid_reg[hidx_reg] <= 1'b1;
                hidx_reg             <= (hidx_reg == LAST_IDX) ? '0 : hidx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sum_reg     <= hsum_next;
        s3_reading_reg <= s2_reading_reg;
    end

    // stage 3: divide the history sum by the depth through a reciprocal multiply
    assign avg_product = s3_sum_reg * RECIP;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_avg_reg     <= avg_product[RECIP_SHIFT+7:RECIP_SHIFT];
            out_reading_reg <= s3_reading_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.avg_value   = out_avg_reg;
    assign res.new_reading = out_reading_reg;
endmodule

/* test/dsfa_reading_checker.sv */
// dust sensor frame averager checker: watches the byte, result and config ports,
// predicts each reading and compares it with what the block returns
// depends on dsfa_pkg, dsfa_rx_if, dsfa_res_if
module dsfa_reading_checker
    import dsfa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    dsfa_rx_if               rx,
    dsfa_res_if              res,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               error_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        byte_t avg_value;
        byte_t new_reading;
    } reading_t;

    // readings predicted but not yet returned, oldest first
    reading_t readings_due [$];

    // predicted block state
    frame_pos_t         pos;
    byte_t              frame_buf [5];
    logic [4:0]         frames_taken;
    logic [TOTAL_W-1:0] frame_total;
    byte_t              history [HISTORY_DEPTH];
    logic [3:0]         hist_idx;
    logic [SUM_W-1:0]   hist_sum;
    logic [CFG_W-1:0]   frames_cfg;

    task automatic flag_error(input string msg);
        begin
            $display("ERROR at %0t: %s", $time, msg);
            error_count++;
        end
    endtask

    // register value clamped to 1..16
    function automatic int frame_limit();
        if (frames_cfg == '0)
            return 1;
        if (frames_cfg > MAX_FRAMES)
            return int'(MAX_FRAMES);
        return int'(frames_cfg);
    endfunction

    // scale the total, saturate, push into the history and predict the mean
    task automatic close_reading();
        logic [63:0] scaled;
        byte_t       reading;
        reading_t    due;
        begin
            scaled  = (64'(frame_total) * 64'(SCALE_MUL)) >> SCALE_SHIFT;
            reading = (scaled > 64'd255) ? 8'hFF : scaled[7:0];
            frame_total  = '0;
            frames_taken = '0;
            if (int'(hist_idx) >= HISTORY_DEPTH)
                hist_idx = '0;
            hist_sum = hist_sum - SUM_W'(history[hist_idx]) + SUM_W'(reading);
            history[hist_idx] = reading;
            hist_idx = (int'(hist_idx) + 1 >= HISTORY_DEPTH) ? 4'd0 : hist_idx + 4'd1;
            due.avg_value   = byte_t'(int'(hist_sum) / HISTORY_DEPTH);
            due.new_reading = reading;
            readings_due.push_back(due);
        end
    endtask

    // accumulate one good frame
    task automatic add_frame();
        begin
            frame_total  = frame_total + TOTAL_W'({frame_buf[0], frame_buf[1]});
            frames_taken = frames_taken + 5'd1;
            if (int'(frames_taken) >= frame_limit())
                close_reading();
        end
    endtask

    // frame parser, one received byte
    task automatic parse_byte(input byte_t b);
        logic [9:0] sum;
        begin
            case (pos) inside
                POS_D1, POS_D2, POS_D3, POS_D4, POS_CK:
                begin
                    frame_buf[int'(pos) - 1] = b;
                    pos = frame_pos_t'(pos + 3'd1);
                end
                POS_END:
                begin
                    sum = 10'(frame_buf[0]) + 10'(frame_buf[1]) + 10'(frame_buf[2])
                        + 10'(frame_buf[3]);
                    if (b == END_BYTE && sum == 10'(frame_buf[4]))
                    begin
                        pos = POS_HUNT;
                        add_frame();
                    end
                    else
                    begin
                        // a failing end byte that is a start byte opens the next frame
                        pos = (b == START_BYTE) ? POS_D1 : POS_HUNT;
                    end
                end
                default:
                begin
                    pos = (b == START_BYTE) ? POS_D1 : POS_HUNT;
                end
            endcase
        end
    endtask

    // compare one returned result with the oldest prediction
    task automatic check_result();
        reading_t due;
        begin
            if (readings_due.size() == 0)
            begin
                flag_error($sformatf("unexpected result avg_value=%0d new_reading=%0d",
                                     res.avg_value, res.new_reading));
            end
            else
            begin
                due = readings_due.pop_front();
                if (res.avg_value !== due.avg_value)
                    flag_error($sformatf("avg_value got %0d expected %0d",
                                         res.avg_value, due.avg_value));
                if (res.new_reading !== due.new_reading)
                    flag_error($sformatf("new_reading got %0d expected %0d",
                                         res.new_reading, due.new_reading));
            end
        end
    endtask

    // sample every transaction at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos          = POS_HUNT;
            frames_taken = '0;
            frame_total  = '0;
            hist_idx     = '0;
            hist_sum     = '0;
            frames_cfg   = CFG_RESET;
            foreach (history[i])
                history[i] = '0;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            readings_due.delete();
            error_count = 0;
            pending    <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (cfg_we)
                frames_cfg = cfg_wdata;
            if (rx.valid && rx.ready)
                parse_byte(rx.rx_byte);
            pending <= readings_due.size();
        end
    end

endmodule

/* test/tb_top.sv */
// dust sensor frame averager testbench top: clock, reset, byte stimulus,
// result back-pressure, config phases, watchdog and verdict
// depends on dsfa_pkg, dsfa_rx_if, dsfa_res_if, dsfa_reading_checker, the block
module tb_top
    import dsfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH     = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    dsfa_rx_if  rx ();
    dsfa_res_if res ();

    int error_count;
    int pending;
    int bytes_sent;
    int idle_cycles;
    bit quiet_rx;
    bit quiet_res;
    bit hold_results;

    dust_sensor_frame_averager #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    dsfa_reading_checker #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .pending     (pending)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, a few long
    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // offer one byte and hold it until the transaction completes
    task automatic send_byte(input byte_t b);
        int gap;
        begin
            gap = idle_len(quiet_rx);
            if (gap > 0)
            begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx.valid   <= 1'b1;
            rx.rx_byte <= b;
            do
            begin
                @(posedge clk);
            end
            while (!rx.ready);
            bytes_sent++;
        end
    endtask

    task automatic send_frame(input byte_t d0, d1, d2, d3, ck, tail);
        begin
            send_byte(START_BYTE);
            send_byte(d0);
            send_byte(d1);
            send_byte(d2);
            send_byte(d3);
            send_byte(ck);
            send_byte(tail);
        end
    endtask

    // data bytes whose sum fits the checksum byte; small totals in some frames
    task automatic pick_payload(output byte_t d0, d1, d2, d3);
        int mode;
        int room;
        begin
            mode = $urandom_range(0, 9);
            d0 = (mode < 6) ? 8'h00 : byte_t'($urandom_range(0, 255));
            room = 255 - int'(d0);
            if (mode < 3)
                d1 = byte_t'($urandom_range(0, 15));
            else
                d1 = byte_t'($urandom_range(0, room));
            room -= int'(d1);
            d2 = byte_t'($urandom_range(0, room));
            room -= int'(d2);
            d3 = byte_t'($urandom_range(0, room));
        end
    endtask

    task automatic send_good_frame();
        byte_t d0, d1, d2, d3;
        begin
            pick_payload(d0, d1, d2, d3);
            send_frame(d0, d1, d2, d3, d0 + d1 + d2 + d3, END_BYTE);
        end
    endtask

    // bad checksum, bad end byte, or fully random content
    task automatic send_broken_frame();
        byte_t d0, d1, d2, d3;
        byte_t tail;
        int    kind;
        begin
            pick_payload(d0, d1, d2, d3);
            kind = $urandom_range(0, 2);
            case (kind)
                0:
                begin
                    send_frame(d0, d1, d2, d3,
                               (d0 + d1 + d2 + d3) ^ byte_t'(1 << $urandom_range(0, 7)),
                               END_BYTE);
                end
                1:
                begin
                    if ($urandom_range(0, 9) < 4)
                        tail = START_BYTE;
                    else
                        tail = byte_t'($urandom_range(0, 254));
                    send_frame(d0, d1, d2, d3, d0 + d1 + d2 + d3, tail);
                end
                default:
                begin
                    send_frame(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                               byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                               byte_t'($urandom_range(0, 255)), END_BYTE);
                end
            endcase
        end
    endtask

    // mostly good frames, the rest broken frames, noise and cut-off frames
    task automatic run_random(input int budget);
        int start;
        int r;
        begin
            start = bytes_sent;
            while (bytes_sent - start < budget)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    send_good_frame();
                else if (r < 88)
                    send_broken_frame();
                else if (r < 94)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
                end
                else
                begin
                    send_byte(START_BYTE);
                    repeat ($urandom_range(1, 5)) send_byte(byte_t'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // wait for every reading to come back, then let the pipeline empty
    task automatic settle();
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // result side ready: random bursts and gaps, one long hold on request
    initial
    begin
        int gap;
        res.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
                gap = idle_len(quiet_res);
                if (gap > 0)
                begin
                    res.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (rx.valid && rx.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // main stimulus
    initial
    begin
        logic [CFG_W-1:0] plan [10];
        plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd2, 5'd5, 5'd17, 5'd1, 5'd8};
        bytes_sent   = 0;
        idle_cycles  = 0;
        quiet_rx     = 1'b0;
        quiet_res    = 1'b0;
        hold_results = 1'b0;
        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero frame, saturating frame, failed frame whose end byte
        // restarts, start byte carried as data and checksum
        write_frames(5'd1);
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, END_BYTE);
        send_frame(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, END_BYTE);
        send_frame(8'hAA, 8'h01, 8'h02, 8'h03, 8'h00, START_BYTE);
        send_byte(8'h00);
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        settle();

        // random phases over a range of frame counts, extremes included
        foreach (plan[i])
        begin
            write_frames(plan[i]);
            run_random((plan[i] >= 5'd8) ? 200 : 70);
            settle();
        end

        // long hold on results while bytes keep coming
        write_frames(5'd1);
        quiet_rx     = 1'b1;
        hold_results = 1'b1;
        repeat (30) send_good_frame();
        quiet_rx = 1'b0;
        settle();

        // back to back on both sides
        write_frames(5'd2);
        quiet_rx  = 1'b1;
        quiet_res = 1'b1;
        run_random(120);
        quiet_rx  = 1'b0;
        quiet_res = 1'b0;
        settle();

        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
